/* sv/cfpa_pkg.sv */
package cfpa_pkg;

  localparam int PAGE_W      = 12;
  localparam int PAGE_TOTAL  = 4096;
  localparam int COLOR_W     = 3;
  localparam int COLOR_COUNT = 8;
  localparam int COUNT_W     = 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch the request
    logic exec;   // push, or scan colours and read link memory
    logic pop;    // retire the allocation using the link read
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_needed;  // allocation with a non-zero free count found a non-empty list
  } dp_status_t;

endpackage

/* sv/cfpa_ctrl.sv */
module cfpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  cfpa_pkg::dp_status_t status,
  output cfpa_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                out_valid
);

  cfpa_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfpa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfpa_pkg::ST_IDLE: begin
        if (start) state_nxt = cfpa_pkg::ST_EXEC;
      end
      cfpa_pkg::ST_EXEC: begin
        state_nxt = status.pop_needed ? cfpa_pkg::ST_POP : cfpa_pkg::ST_IDLE;
      end
      cfpa_pkg::ST_POP: begin
        state_nxt = cfpa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cfpa_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    out_valid_nxt = 1'b0;
    case (state_r)
      cfpa_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      cfpa_pkg::ST_EXEC: begin
        cmd.exec      = 1'b1;
        out_valid_nxt = !status.pop_needed;
      end
      cfpa_pkg::ST_POP: begin
        cmd.pop       = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign busy      = (state_r != cfpa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* sv/cfpa_datapath.sv */
module cfpa_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfpa_pkg::dp_cmd_t                  cmd,
  input  logic                              in_action,
  input  logic                              in_hint_present,
  input  logic [cfpa_pkg::PAGE_W-1:0]       in_page,
  output cfpa_pkg::dp_status_t               status,
  output logic [cfpa_pkg::PAGE_W-1:0]       out_granted_page,
  output logic                              out_ok
);

  localparam int PW = cfpa_pkg::PAGE_W;
  localparam int CW = cfpa_pkg::COLOR_W;
  localparam int NC = cfpa_pkg::COLOR_COUNT;

  // request
  logic          act_r;
  logic          hint_r;
  logic [PW-1:0] page_r;

  // list state
  logic [PW-1:0]                    head_r  [NC];
  logic [NC-1:0]                    empty_r;
  logic [cfpa_pkg::COUNT_W-1:0]     count_r;
  logic [CW-1:0]                    rot_r;
  logic [CW-1:0]                    sel_r;

  // link memory: {last-in-list, next page}
  logic [PW:0]   link_mem [cfpa_pkg::PAGE_TOTAL];
  logic [PW:0]   link_rd_r;

  logic [PW-1:0] out_page_r;
  logic          out_ok_r;

  logic [CW-1:0] start_color;
  logic [CW-1:0] scan_color;
  logic [CW-1:0] cand;
  logic [CW-1:0] push_color;
  logic          found;
  logic          is_alloc;
  logic          have_free;

  assign is_alloc   = (act_r == cfpa_pkg::ACT_ALLOC);
  assign have_free  = (count_r != '0);
  assign push_color = page_r[CW-1:0];
  assign start_color = hint_r ? page_r[CW-1:0] : rot_r + CW'(1);

  // first non-empty colour from the start colour, wrapping
  always_comb begin
    found      = 1'b0;
    scan_color = start_color;
    cand       = start_color;
    for (int i = 0; i < NC; i++) begin
      cand = start_color + CW'(i);
      if (!found && !empty_r[cand]) begin
        found      = 1'b1;
        scan_color = cand;
      end
    end
  end

  assign status.pop_needed = is_alloc && have_free && found;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      hint_r <= in_hint_present;
      page_r <= in_page;
    end
  end

  // link memory: written by a free, read at the scanned head on every EXEC
  always_ff @(posedge clk) begin
    if (cmd.exec && !is_alloc) begin
      link_mem[page_r] <= {empty_r[push_color], head_r[push_color]};
    end
    if (cmd.exec) begin
      link_rd_r <= link_mem[head_r[scan_color]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_r <= '1;
      count_r <= '0;
      rot_r   <= '0;
    end else if (cmd.exec) begin
      if (!is_alloc) begin
        empty_r[push_color] <= 1'b0;
        if (count_r != cfpa_pkg::COUNT_MAX) count_r <= count_r + cfpa_pkg::COUNT_W'(1);
      end else if (have_free && !hint_r) begin
        rot_r <= start_color;
      end
    end else if (cmd.pop) begin
      if (link_rd_r[PW]) empty_r[sel_r] <= 1'b1;
      count_r <= count_r - cfpa_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      sel_r <= scan_color;
      if (!is_alloc) begin
        head_r[push_color] <= page_r;
        out_page_r         <= '0;
        out_ok_r           <= 1'b1;
      end else if (!status.pop_needed) begin
        out_page_r <= '0;
        out_ok_r   <= 1'b0;
      end
    end else if (cmd.pop) begin
      out_page_r <= head_r[sel_r];
      out_ok_r   <= 1'b1;
      if (!link_rd_r[PW]) head_r[sel_r] <= link_rd_r[PW-1:0];
    end
  end

  assign out_granted_page = out_page_r;
  assign out_ok           = out_ok_r;

endmodule

/* sv/colored_free_page_allocator.sv */
// Sequence: a free and a failed allocate strobe their result after EXEC, a successful allocate
// after EXEC and POP (colour scan, then registered link-memory read).
// One transaction at a time; busy covers the whole transaction.
// Reset: synchronous, active low; every colour list empty, free count and rotating colour zero.
// List heads and link memory are not cleared (no clearing pass); the receiver cannot stall.
module colored_free_page_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic                        in_hint_present,
  input  logic [cfpa_pkg::PAGE_W-1:0] in_page,
  output logic                        out_valid,
  output logic [cfpa_pkg::PAGE_W-1:0] out_granted_page,
  output logic                        out_ok
);

  // Controller sequences IDLE -> EXEC (-> POP) -> IDLE.
  // EXEC: a free pushes onto its colour list; an allocate picks the start colour,
  //       scans for the first non-empty list and reads the head's link entry.
  // POP:  the link read replaces the head, or marks the list empty at its last page.
  cfpa_pkg::dp_cmd_t    cmd;
  cfpa_pkg::dp_status_t status;

  cfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Result registers live in the datapath; the strobe comes from the controller.
  cfpa_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_action        (in_action),
    .in_hint_present  (in_hint_present),
    .in_page          (in_page),
    .status           (status),
    .out_granted_page (out_granted_page),
    .out_ok           (out_ok)
  );

`ifndef NO_ASSERTIONS
  // an accepted transaction holds the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accept did not raise busy");

  // a result only ends a transaction
  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside end of transaction");

  // failures grant no page
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_granted_page == '0))
    else $error("failed transaction granted a page");
`endif

endmodule
